// ===== rtl/assert_macros.svh =====
// Assertion macros shared by the path unit RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked on every rising edge outside reset.
`define RGAP_ASSERT_IMP(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked on every rising edge outside reset.
`define RGAP_ASSERT_NXT(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/rgap_pkg.sv =====
// Shared types, constants and helpers of the radius graph path unit.
package rgap_pkg;

  localparam int FIELD_W = 16;
  localparam int CFG_W   = 38;
  localparam int OIDX_W  = 6;
  localparam int COST_W  = 32;

  localparam logic REQ_LOAD  = 1'b0;
  localparam logic REQ_QUERY = 1'b1;

  typedef struct packed {
    logic                      req_type;
    logic                      first_node;
    logic signed [FIELD_W-1:0] pos_x;
    logic signed [FIELD_W-1:0] pos_y;
    logic signed [FIELD_W-1:0] pos_z;
    logic signed [FIELD_W-1:0] goal_x;
    logic signed [FIELD_W-1:0] goal_y;
    logic signed [FIELD_W-1:0] goal_z;
  } in_t;

  typedef struct packed {
    logic                      found;
    logic [OIDX_W-1:0]         node_index;
    logic signed [FIELD_W-1:0] out_x;
    logic signed [FIELD_W-1:0] out_y;
    logic signed [FIELD_W-1:0] out_z;
    logic                      last;
  } out_t;

  // Add two path costs, clamping at the all-ones value.
  function automatic logic [COST_W-1:0] sat_add(logic [COST_W-1:0] a, logic [COST_W-1:0] b);
    logic [COST_W:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[COST_W] ? {COST_W{1'b1}} : s[COST_W-1:0];
  endfunction

endpackage

// ===== rtl/rgap_dist.sv =====
// Squared Euclidean distance unit: one shared multiplier, one axis a cycle.
module rgap_dist import rgap_pkg::*; #(
  parameter int CW = 16
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 start_i,
  input  logic [3*CW-1:0]      a_i,
  input  logic [3*CW-1:0]      b_i,
  output logic                 done_o,
  output logic [2*CW+3:0]      d2_o
);

  localparam int DW  = CW + 1;
  localparam int SQW = 2*CW + 4;

  logic [DW-1:0]  dx_q, dy_q, dz_q;
  logic [DW-1:0]  ax, ay, az;
  logic [1:0]     step_q;
  logic           busy_q, done_q;
  logic [SQW-1:0] acc_q;
  logic [DW-1:0]  sel;
  logic [2*DW-1:0] sq;

  function automatic logic [DW-1:0] abs_diff(logic [CW-1:0] a, logic [CW-1:0] b);
    logic signed [DW-1:0] d;
    d = $signed({a[CW-1], a}) - $signed({b[CW-1], b});
    return d[DW-1] ? DW'(-d) : DW'(d);
  endfunction

  // Form absolute differences per axis
  assign ax = abs_diff(a_i[3*CW-1:2*CW], b_i[3*CW-1:2*CW]);
  assign ay = abs_diff(a_i[2*CW-1:CW],   b_i[2*CW-1:CW]);
  assign az = abs_diff(a_i[CW-1:0],      b_i[CW-1:0]);

  // Pick the axis of this step and square it
  always_comb begin
    unique case (step_q)
      2'd0:    sel = dx_q;
      2'd1:    sel = dy_q;
      default: sel = dz_q;
    endcase
    sq = sel * sel;
  end

  // Latch operands, then accumulate one square a cycle
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      step_q <= '0;
      acc_q  <= '0;
      dx_q   <= '0;
      dy_q   <= '0;
      dz_q   <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        dx_q   <= ax;
        dy_q   <= ay;
        dz_q   <= az;
        acc_q  <= '0;
        step_q <= '0;
        busy_q <= 1'b1;
      end else if (busy_q) begin
        acc_q  <= acc_q + SQW'(sq);
        step_q <= step_q + 2'd1;
        if (step_q == 2'd2) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  assign done_o = done_q;
  assign d2_o   = acc_q;

endmodule

// ===== rtl/rgap_isqrt.sv =====
// Iterative floor square root, one result bit a cycle.
module rgap_isqrt import rgap_pkg::*; #(
  parameter int VW = 36
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  input  logic [VW-1:0]     val_i,
  output logic              done_o,
  output logic [VW/2-1:0]   root_o
);

  localparam int RW = VW / 2;
  localparam int SW = $clog2(RW);

  logic [VW-1:0]   val_q;
  logic [RW+1:0]   rem_q;
  logic [RW-1:0]   root_q;
  logic [SW-1:0]   step_q;
  logic            busy_q, done_q;
  logic [RW+3:0]   rem_sh, trial;
  logic            take;

  // Bring down two bits and try the next root bit
  always_comb begin
    rem_sh = {rem_q, val_q[VW-1:VW-2]};
    trial  = (RW+4)'({root_q, 2'b01});
    take   = (rem_sh >= trial);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      step_q <= '0;
      val_q  <= '0;
      rem_q  <= '0;
      root_q <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        val_q  <= val_i;
        rem_q  <= '0;
        root_q <= '0;
        step_q <= '0;
        busy_q <= 1'b1;
      end else if (busy_q) begin
        val_q  <= {val_q[VW-3:0], 2'b00};
        rem_q  <= take ? (RW+2)'(rem_sh - trial) : rem_sh[RW+1:0];
        root_q <= {root_q[RW-2:0], take};
        step_q <= step_q + SW'(1);
        if (step_q == SW'(RW-1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  assign done_o = done_q;
  assign root_o = root_q;

endmodule

// ===== rtl/radius_graph_a_star_path_unit.sv =====
// Top level of the radius graph A* path unit: sequencer, node and search memories.
`include "assert_macros.svh"

// One item is worked on at a time; the input stalls until the item is done.
// A load reads each node already stored, starts the shared distance unit, waits
// on it and compares against the radius; where the nodes are linked, a
// read-modify-write of the linked row follows, and the new row is written to
// close. A query snaps start and then goal by the same pass over the stored
// nodes, clears the search table and seeds the start node (distance and
// bit-serial square root). Each expansion then scans every node to pick the
// open node, skips each node that is not a neighbour, runs distance and square
// root per neighbour and both again per improved neighbour. The path is walked
// back, then sent node by node, which takes longer while the output stalls. The
// query time is set by the single distance unit and square root unit and by the
// single read port of the search memory; it depends on the graph. No clearing
// pass runs after reset.
module radius_graph_a_star_path_unit import rgap_pkg::*; #(
  parameter int MAX_NODES  = 64,
  parameter int COORD_BITS = 16
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_stall_o,
  input  in_t              in_data_i,
  output logic             out_valid_o,
  input  logic             out_stall_i,
  output out_t             out_data_o,
  input  logic             cfg_valid_i,
  output logic             cfg_ready_o,
  input  logic [CFG_W-1:0] cfg_data_i
);

  localparam int CW   = COORD_BITS;
  localparam int IW   = $clog2(MAX_NODES);
  localparam int CNTW = $clog2(MAX_NODES + 1);
  localparam int SQW  = 2*CW + 4;
  localparam int RW   = SQW / 2;
  localparam int PW   = 3*CW;
  localparam int CMPW = (SQW > CFG_W) ? SQW : CFG_W;

  // Single beat sent when there is no path
  localparam out_t NO_PATH = '{found: 1'b0, node_index: '0, out_x: '0, out_y: '0,
                               out_z: '0, last: 1'b1};

  typedef struct packed {
    logic              reached;
    logic              is_open;
    logic [IW-1:0]     pred;
    logic [COST_W-1:0] cost;
    logic [COST_W-1:0] est;
  } srch_t;

  typedef enum logic [4:0] {
    S_IDLE, S_L_RD, S_L_DST, S_L_CHK, S_L_ADJ,
    S_N_RD, S_N_DST, S_N_CHK, S_INIT, S_INIT2,
    S_SEL, S_SEL_CHK, S_SEL_END, S_EXP0, S_EXP_RD, S_EXP_DST, S_EXP_T, S_EXP_W,
    S_P_PUSH, S_P_PRED, S_E_RD, S_E_POS, S_E_OUT, S_OUT,
    S_W_DIST, S_W_SQRT
  } state_e;

  // Memories
  logic [PW-1:0]        pos_mem  [MAX_NODES];
  logic [MAX_NODES-1:0] adj_mem  [MAX_NODES];
  srch_t                srch_mem [MAX_NODES];
  logic [IW-1:0]        stk_mem  [MAX_NODES];

  logic [PW-1:0]        pos_rd_q, pos_wd;
  logic [MAX_NODES-1:0] adj_rd_q, adj_wd;
  srch_t                srch_rd_q, srch_wd;
  logic [IW-1:0]        stk_rd_q;
  logic [IW-1:0]        pos_ra, pos_wa, adj_ra, adj_wa, srch_ra, srch_wa, stk_ra, stk_wa;
  logic                 pos_we, adj_we, srch_we, stk_we;

  // Sequencer registers
  state_e               state_q, ret_q;
  logic [CNTW-1:0]      count_q, cnt_q, len_q, k_q;
  logic [CFG_W-1:0]     radius_q;
  logic [IW-1:0]        new_q, best_q, s_q, g_q, cur_q, idx_q;
  logic [PW-1:0]        new_pos_q, qs_q, qg_q, cand_q, best_pos_q, spos_q, gpos_q;
  logic [PW-1:0]        cur_pos_q, nb_pos_q;
  logic [SQW-1:0]       bd_q;
  logic                 pass_q, have_q, need_sqrt_q;
  srch_t                cur_ent_q, nb_ent_q;
  logic [MAX_NODES-1:0] row_q;
  logic [COST_W-1:0]    t_q;
  out_t                 out_q;

  // Arithmetic units
  logic                 dist_start, dist_done, sqrt_done;
  logic [PW-1:0]        dist_a, dist_b;
  logic [SQW-1:0]       d2;
  logic [RW-1:0]        root;

  logic                 in_acc;
  logic [CNTW-1:0]      nn;
  logic [PW-1:0]        in_pos, in_goal;
  logic [COST_W-1:0]    t_new, est_new;
  logic [IW-1:0]        cidx;

  function automatic logic [CW-1:0] from_field(logic [FIELD_W-1:0] f);
    return CW'(f);
  endfunction

  function automatic logic signed [FIELD_W-1:0] to_field(logic [CW-1:0] c);
    return FIELD_W'($signed(c));
  endfunction

  rgap_dist #(.CW(CW)) u_dist (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (dist_start),
    .a_i     (dist_a),
    .b_i     (dist_b),
    .done_o  (dist_done),
    .d2_o    (d2)
  );

  rgap_isqrt #(.VW(SQW)) u_isqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (dist_done && need_sqrt_q && (state_q == S_W_DIST)),
    .val_i   (d2),
    .done_o  (sqrt_done),
    .root_o  (root)
  );

  assign in_stall_o  = (state_q != S_IDLE);
  assign in_acc      = in_valid_i && (state_q == S_IDLE);
  assign cfg_ready_o = 1'b1;
  assign out_valid_o = (state_q == S_OUT);
  assign out_data_o  = out_q;

  assign nn      = in_data_i.first_node ? '0 : count_q;
  assign in_pos  = {from_field(in_data_i.pos_x), from_field(in_data_i.pos_y),
                    from_field(in_data_i.pos_z)};
  assign in_goal = {from_field(in_data_i.goal_x), from_field(in_data_i.goal_y),
                    from_field(in_data_i.goal_z)};
  assign cidx    = cnt_q[IW-1:0];
  assign t_new   = sat_add(cur_ent_q.cost, COST_W'(root));
  assign est_new = sat_add(t_q, COST_W'(root));

  // Memory ports and unit starts, chosen by state
  always_comb begin
    pos_ra     = cidx;
    pos_we     = 1'b0;
    pos_wa     = nn[IW-1:0];
    pos_wd     = in_pos;
    adj_ra     = cidx;
    adj_we     = 1'b0;
    adj_wa     = cidx;
    adj_wd     = adj_rd_q | (MAX_NODES'(1) << new_q);
    srch_ra    = cidx;
    srch_we    = 1'b0;
    srch_wa    = cidx;
    srch_wd    = '0;
    stk_ra     = k_q[IW-1:0];
    stk_we     = 1'b0;
    stk_wa     = len_q[IW-1:0];
    dist_start = 1'b0;
    dist_a     = pos_rd_q;
    dist_b     = new_pos_q;
    case (state_q)
      S_IDLE: begin
        pos_we = in_acc && (in_data_i.req_type == REQ_LOAD) &&
                 (nn < CNTW'(MAX_NODES));
      end
      S_L_RD: begin
        if (cnt_q == count_q) begin
          adj_we = 1'b1;
          adj_wa = new_q;
          adj_wd = row_q;
        end
      end
      S_L_DST: dist_start = 1'b1;
      S_L_ADJ: adj_we = 1'b1;
      S_N_DST: begin
        dist_start = 1'b1;
        dist_b     = pass_q ? qg_q : qs_q;
      end
      S_INIT: begin
        if (cnt_q == count_q) begin
          dist_start = 1'b1;
          dist_a     = spos_q;
          dist_b     = gpos_q;
        end else begin
          srch_we = 1'b1;
        end
      end
      S_INIT2: begin
        srch_we = 1'b1;
        srch_wa = s_q;
        srch_wd = '{reached: 1'b1, is_open: 1'b1, pred: '0, cost: '0,
                    est: COST_W'(root)};
      end
      S_SEL_END: begin
        pos_ra  = cur_q;
        adj_ra  = cur_q;
        srch_we = have_q;
        srch_wa = cur_q;
        srch_wd = cur_ent_q;
        srch_wd.is_open = 1'b0;
      end
      S_EXP_DST: begin
        dist_start = 1'b1;
        dist_a     = cur_pos_q;
        dist_b     = pos_rd_q;
      end
      S_EXP_T: begin
        dist_start = !nb_ent_q.reached || (t_new < nb_ent_q.cost);
        dist_a     = nb_pos_q;
        dist_b     = gpos_q;
      end
      S_EXP_W: begin
        srch_we = 1'b1;
        srch_wd = '{reached: 1'b1, is_open: 1'b1, pred: cur_q, cost: t_q, est: est_new};
      end
      S_P_PUSH: begin
        srch_ra = idx_q;
        stk_we  = 1'b1;
      end
      S_E_POS: pos_ra = stk_rd_q;
      default: ;
    endcase
  end

  // Synchronous memories, one read and one write port each
  always_ff @(posedge clk_i) begin
    if (pos_we) pos_mem[pos_wa] <= pos_wd;
    pos_rd_q <= pos_mem[pos_ra];
  end

  always_ff @(posedge clk_i) begin
    if (adj_we) adj_mem[adj_wa] <= adj_wd;
    adj_rd_q <= adj_mem[adj_ra];
  end

  always_ff @(posedge clk_i) begin
    if (srch_we) srch_mem[srch_wa] <= srch_wd;
    srch_rd_q <= srch_mem[srch_ra];
  end

  always_ff @(posedge clk_i) begin
    if (stk_we) stk_mem[stk_wa] <= idx_q;
    stk_rd_q <= stk_mem[stk_ra];
  end

  // Sequencer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      ret_q       <= S_IDLE;
      count_q     <= '0;
      radius_q    <= '0;
      cnt_q       <= '0;
      len_q       <= '0;
      k_q         <= '0;
      new_q       <= '0;
      best_q      <= '0;
      s_q         <= '0;
      g_q         <= '0;
      cur_q       <= '0;
      idx_q       <= '0;
      new_pos_q   <= '0;
      qs_q        <= '0;
      qg_q        <= '0;
      cand_q      <= '0;
      best_pos_q  <= '0;
      spos_q      <= '0;
      gpos_q      <= '0;
      cur_pos_q   <= '0;
      nb_pos_q    <= '0;
      bd_q        <= '0;
      pass_q      <= 1'b0;
      have_q      <= 1'b0;
      need_sqrt_q <= 1'b0;
      cur_ent_q   <= '0;
      nb_ent_q    <= '0;
      row_q       <= '0;
      t_q         <= '0;
      out_q       <= '0;
    end else begin
      if (cfg_valid_i) radius_q <= cfg_data_i;
      unique case (state_q)
        S_IDLE: begin
          if (in_acc) begin
            cnt_q <= '0;
            if (in_data_i.req_type == REQ_LOAD) begin
              // Store the node, then link it to every earlier one within the radius
              if (nn < CNTW'(MAX_NODES)) begin
                count_q   <= nn;
                new_q     <= nn[IW-1:0];
                new_pos_q <= in_pos;
                row_q     <= '0;
                state_q   <= S_L_RD;
              end
            end else if (count_q == '0) begin
              out_q   <= NO_PATH;
              state_q <= S_OUT;
            end else begin
              qs_q    <= in_pos;
              qg_q    <= in_goal;
              pass_q  <= 1'b0;
              state_q <= S_N_RD;
            end
          end
        end
        S_L_RD: begin
          if (cnt_q == count_q) begin
            count_q <= count_q + CNTW'(1);
            state_q <= S_IDLE;
          end else begin
            state_q <= S_L_DST;
          end
        end
        S_L_DST: begin
          need_sqrt_q <= 1'b0;
          ret_q       <= S_L_CHK;
          state_q     <= S_W_DIST;
        end
        S_L_CHK: begin
          if (CMPW'(d2) <= CMPW'(radius_q)) begin
            row_q[cidx] <= 1'b1;
            state_q     <= S_L_ADJ;
          end else begin
            cnt_q   <= cnt_q + CNTW'(1);
            state_q <= S_L_RD;
          end
        end
        S_L_ADJ: begin
          cnt_q   <= cnt_q + CNTW'(1);
          state_q <= S_L_RD;
        end
        // Snap start, then goal, to the nearest stored node
        S_N_RD: begin
          if (cnt_q == count_q) begin
            cnt_q <= '0;
            if (!pass_q) begin
              s_q     <= best_q;
              spos_q  <= best_pos_q;
              pass_q  <= 1'b1;
            end else begin
              g_q     <= best_q;
              gpos_q  <= best_pos_q;
              state_q <= S_INIT;
            end
          end else begin
            state_q <= S_N_DST;
          end
        end
        S_N_DST: begin
          cand_q      <= pos_rd_q;
          need_sqrt_q <= 1'b0;
          ret_q       <= S_N_CHK;
          state_q     <= S_W_DIST;
        end
        S_N_CHK: begin
          if ((cnt_q == '0) || (d2 < bd_q)) begin
            bd_q       <= d2;
            best_q     <= cidx;
            best_pos_q <= cand_q;
          end
          cnt_q   <= cnt_q + CNTW'(1);
          state_q <= S_N_RD;
        end
        // Clear the search table, then seed the start node
        S_INIT: begin
          if (cnt_q == count_q) begin
            need_sqrt_q <= 1'b1;
            ret_q       <= S_INIT2;
            state_q     <= S_W_DIST;
          end else begin
            cnt_q <= cnt_q + CNTW'(1);
          end
        end
        S_INIT2: begin
          cnt_q   <= '0;
          have_q  <= 1'b0;
          state_q <= S_SEL;
        end
        // Pick the open node with the lowest estimate, lowest index on ties
        S_SEL: state_q <= (cnt_q == count_q) ? S_SEL_END : S_SEL_CHK;
        S_SEL_CHK: begin
          if (srch_rd_q.is_open && (!have_q || (srch_rd_q.est < cur_ent_q.est))) begin
            have_q    <= 1'b1;
            cur_q     <= cidx;
            cur_ent_q <= srch_rd_q;
          end
          cnt_q   <= cnt_q + CNTW'(1);
          state_q <= S_SEL;
        end
        S_SEL_END: begin
          if (!have_q) begin
            out_q   <= NO_PATH;
            state_q <= S_OUT;
          end else if (cur_q == g_q) begin
            idx_q   <= g_q;
            len_q   <= '0;
            state_q <= S_P_PUSH;
          end else begin
            state_q <= S_EXP0;
          end
        end
        S_EXP0: begin
          row_q     <= adj_rd_q;
          cur_pos_q <= pos_rd_q;
          cnt_q     <= '0;
          state_q   <= S_EXP_RD;
        end
        // Relax each neighbour of the expanded node
        S_EXP_RD: begin
          if (cnt_q == count_q) begin
            cnt_q   <= '0;
            have_q  <= 1'b0;
            state_q <= S_SEL;
          end else if (!row_q[cidx]) begin
            cnt_q <= cnt_q + CNTW'(1);
          end else begin
            state_q <= S_EXP_DST;
          end
        end
        S_EXP_DST: begin
          nb_pos_q    <= pos_rd_q;
          nb_ent_q    <= srch_rd_q;
          need_sqrt_q <= 1'b1;
          ret_q       <= S_EXP_T;
          state_q     <= S_W_DIST;
        end
        S_EXP_T: begin
          if (!nb_ent_q.reached || (t_new < nb_ent_q.cost)) begin
            t_q     <= t_new;
            ret_q   <= S_EXP_W;
            state_q <= S_W_DIST;
          end else begin
            cnt_q   <= cnt_q + CNTW'(1);
            state_q <= S_EXP_RD;
          end
        end
        S_EXP_W: begin
          cnt_q   <= cnt_q + CNTW'(1);
          state_q <= S_EXP_RD;
        end
        // Walk predecessors from goal back to start
        S_P_PUSH: begin
          len_q <= len_q + CNTW'(1);
          if ((idx_q == s_q) || (len_q + CNTW'(1) == CNTW'(MAX_NODES))) begin
            k_q     <= len_q;
            state_q <= S_E_RD;
          end else begin
            state_q <= S_P_PRED;
          end
        end
        S_P_PRED: begin
          idx_q   <= srch_rd_q.pred;
          state_q <= S_P_PUSH;
        end
        // Send the path from start to goal
        S_E_RD:  state_q <= S_E_POS;
        S_E_POS: begin
          idx_q   <= stk_rd_q;
          state_q <= S_E_OUT;
        end
        S_E_OUT: begin
          out_q   <= '{found: 1'b1, node_index: OIDX_W'(idx_q),
                       out_x: to_field(pos_rd_q[3*CW-1:2*CW]),
                       out_y: to_field(pos_rd_q[2*CW-1:CW]),
                       out_z: to_field(pos_rd_q[CW-1:0]),
                       last: (k_q == '0)};
          state_q <= S_OUT;
        end
        S_OUT: begin
          if (!out_stall_i) begin
            if (out_q.last) begin
              state_q <= S_IDLE;
            end else begin
              k_q     <= k_q - CNTW'(1);
              state_q <= S_E_RD;
            end
          end
        end
        // Wait on the distance unit, then the square root if asked for
        S_W_DIST: begin
          if (dist_done) state_q <= need_sqrt_q ? S_W_SQRT : ret_q;
        end
        S_W_SQRT: begin
          if (sqrt_done) state_q <= ret_q;
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  // Checks on results
  `RGAP_ASSERT_IMP(a_found_idx, clk_i, rst_ni, out_valid_o && out_data_o.found, 7'(out_data_o.node_index) < 7'(count_q), "path node index beyond stored nodes")
  `RGAP_ASSERT_IMP(a_fail_last, clk_i, rst_ni, out_valid_o && !out_data_o.found, out_data_o.last, "no-path beat not marked last")
  `RGAP_ASSERT_NXT(a_last_ends, clk_i, rst_ni, out_valid_o && !out_stall_i && out_data_o.last, !out_valid_o && !in_stall_o, "query did not finish after last beat")

endmodule

// ===== tb/sv/radius_graph_a_star_path_unit_test.sv =====
// Testbench for the radius graph A* path unit: directed table, full-table fill, then random loads and queries.
`timescale 1ns / 100ps

module radius_graph_a_star_path_unit_test;
  import rgap_pkg::*;

  localparam int NODES      = 64;
  localparam int LOAD_WAIT  = 500;
  localparam int IDLE_LIMIT = 200000;
  localparam logic [CFG_W-1:0] RADIUS_MAX = 38'd206158430208;

  typedef enum logic {ROW_BEAT, ROW_RADIUS} row_kind_e;

  typedef struct {
    row_kind_e        kind;
    in_t              beat;
    logic [CFG_W-1:0] radius;
    bit               typed;
    out_t             want;
  } row_t;

  logic             clk_i = 1'b0;
  logic             rst_ni = 1'b0;
  logic             in_valid_i = 1'b0;
  logic             in_stall_o;
  in_t              in_data_i = '0;
  logic             out_valid_o;
  logic             out_stall_i = 1'b0;
  out_t             out_data_o;
  logic             cfg_valid_i = 1'b0;
  logic             cfg_ready_o;
  logic [CFG_W-1:0] cfg_data_i = '0;

  // Shadow copy of the node table and the link radius
  logic signed [FIELD_W-1:0] node_px [NODES];
  logic signed [FIELD_W-1:0] node_py [NODES];
  logic signed [FIELD_W-1:0] node_pz [NODES];
  logic [NODES-1:0]          link_row [NODES];
  int unsigned               stored_nodes = 0;
  logic [CFG_W-1:0]          link_radius = '0;

  out_t path_q[$];
  row_t rows[$];
  int   mismatches = 0;
  int   tx_idle_pct = 0;
  int   rx_idle_pct = 0;
  int   hold_req = 0;
  int   hold_done = 0;
  int   hold_left = 0;
  int   quiet_cycles = 0;

  radius_graph_a_star_path_unit uut (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_o, .in_data_i,
    .out_valid_o, .out_stall_i, .out_data_o,
    .cfg_valid_i, .cfg_ready_o, .cfg_data_i
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  // ---------------------------------------------------------------- predictor
  function automatic longint unsigned sq_dist(logic signed [FIELD_W-1:0] ax, ay, az,
                                              logic signed [FIELD_W-1:0] bx, by, bz);
    longint dx, dy, dz;
    dx = longint'(ax) - longint'(bx);
    dy = longint'(ay) - longint'(by);
    dz = longint'(az) - longint'(bz);
    return longint'(dx * dx + dy * dy + dz * dz);
  endfunction

  // Floor square root, two bits per step
  function automatic int unsigned int_sqrt(longint unsigned v);
    longint unsigned res, b;
    res = 0;
    b = 64'd1 << 62;
    while (b > v) b = b >> 2;
    while (b != 0) begin
      if (v >= res + b) begin
        v = v - (res + b);
        res = (res >> 1) + b;
      end else begin
        res = res >> 1;
      end
      b = b >> 2;
    end
    return int'(res);
  endfunction

  function automatic int unsigned edge_len(int a, int b);
    return int_sqrt(sq_dist(node_px[a], node_py[a], node_pz[a],
                            node_px[b], node_py[b], node_pz[b]));
  endfunction

  function automatic int unsigned add_clamp(int unsigned a, int unsigned b);
    longint unsigned s;
    s = longint'(a) + longint'(b);
    return (s > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : int'(s);
  endfunction

  // Append one expected result beat
  function automatic void want_beat(out_t r);
    path_q.insert(path_q.size(), r);
  endfunction

  // Snap a point to its nearest node; lowest index wins ties
  function automatic int snap_node(logic signed [FIELD_W-1:0] x, y, z);
    int best;
    longint unsigned bd, d;
    best = 0;
    bd = sq_dist(node_px[0], node_py[0], node_pz[0], x, y, z);
    for (int i = 1; i < stored_nodes; i++) begin
      d = sq_dist(node_px[i], node_py[i], node_pz[i], x, y, z);
      if (d < bd) begin
        bd = d;
        best = i;
      end
    end
    return best;
  endfunction

  // Update the shadow table for a load, or queue the expected beats of a query: its path nodes or a no-path beat
  function automatic void predict_path(in_t b, bit keep);
    int unsigned cost [NODES];
    int unsigned est [NODES];
    int          prev [NODES];
    bit          open_n [NODES];
    bit          seen [NODES];
    int          trail[$];
    int          n, s, g, cur, v;
    int unsigned t;
    out_t        r;
    n = stored_nodes;
    if (b.req_type == REQ_LOAD) begin
      if (b.first_node) stored_nodes = 0;
      if (stored_nodes >= NODES) return;
      n = stored_nodes;
      node_px[n] = b.pos_x;
      node_py[n] = b.pos_y;
      node_pz[n] = b.pos_z;
      link_row[n] = '0;
      for (int i = 0; i < n; i++) begin
        if (sq_dist(node_px[i], node_py[i], node_pz[i], b.pos_x, b.pos_y, b.pos_z)
            <= link_radius) begin
          link_row[n][i] = 1'b1;
          link_row[i][n] = 1'b1;
        end
      end
      stored_nodes = n + 1;
      return;
    end
    if (!keep) return;
    r = '0;
    r.last = 1'b1;
    if (n == 0) begin
      want_beat(r);
      return;
    end
    s = snap_node(b.pos_x, b.pos_y, b.pos_z);
    g = snap_node(b.goal_x, b.goal_y, b.goal_z);
    for (int i = 0; i < n; i++) begin
      cost[i] = 0; est[i] = 0; prev[i] = -1; open_n[i] = 0; seen[i] = 0;
    end
    seen[s] = 1;
    est[s] = edge_len(s, g);
    open_n[s] = 1;
    // Expand the cheapest open node until the goal comes off the open set
    forever begin
      cur = -1;
      for (int i = 0; i < n; i++)
        if (open_n[i] && (cur < 0 || est[i] < est[cur])) cur = i;
      if (cur < 0 || cur == g) break;
      open_n[cur] = 0;
      for (int i = 0; i < n; i++) begin
        if (!link_row[cur][i]) continue;
        t = add_clamp(cost[cur], edge_len(cur, i));
        if (!seen[i] || t < cost[i]) begin
          seen[i] = 1;
          prev[i] = cur;
          cost[i] = t;
          est[i] = add_clamp(t, edge_len(i, g));
          open_n[i] = 1;
        end
      end
    end
    if (!seen[g]) begin
      want_beat(r);
      return;
    end
    v = g;
    while (v >= 0 && trail.size() < NODES) begin
      trail.push_front(v);
      if (v == s) break;
      v = prev[v];
    end
    foreach (trail[k]) begin
      r.found = 1'b1;
      r.node_index = trail[k][OIDX_W-1:0];
      r.out_x = node_px[trail[k]];
      r.out_y = node_py[trail[k]];
      r.out_z = node_pz[trail[k]];
      r.last = (k == trail.size() - 1);
      want_beat(r);
    end
  endfunction

  // ----------------------------------------------------------------- checking
  task automatic report(string what, longint got, longint want);
    $display("path beat %s: got %0h, want %0h", what, got, want);
    mismatches++;
  endtask

  always @(posedge clk_i) begin
    out_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (path_q.size() == 0) begin
        report("unexpected", out_data_o, 0);
      end else begin
        want = path_q.pop_front();
        if (out_data_o.found !== want.found) report("found", out_data_o.found, want.found);
        if (out_data_o.node_index !== want.node_index)
          report("node_index", out_data_o.node_index, want.node_index);
        if (out_data_o.out_x !== want.out_x) report("out_x", out_data_o.out_x, want.out_x);
        if (out_data_o.out_y !== want.out_y) report("out_y", out_data_o.out_y, want.out_y);
        if (out_data_o.out_z !== want.out_z) report("out_z", out_data_o.out_z, want.out_z);
        if (out_data_o.last !== want.last) report("last", out_data_o.last, want.last);
      end
    end
  end

  // Receiver: random stall, or a long hold-off when asked for
  always @(posedge clk_i) begin
    if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      out_stall_i <= 1'b1;
    end else if (hold_req != hold_done) begin
      hold_done <= hold_req;
      hold_left <= 400;
      out_stall_i <= 1'b1;
    end else begin
      out_stall_i <= ($urandom_range(0, 99) < rx_idle_pct);
    end
  end

  // Watchdog on cycles with no beat moving anywhere
  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i) ||
        (cfg_valid_i && cfg_ready_o) || !rst_ni) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= IDLE_LIMIT) begin
      $display("radius_graph_a_star_path_unit: mismatch");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // ------------------------------------------------------------------ driving
  task automatic send_beat(in_t b, bit keep = 1);
    while ($urandom_range(0, 99) < tx_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i <= b;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    predict_path(b, keep);
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (path_q.size() != 0) @(posedge clk_i);
  endtask

  // Write the radius only with the block idle; wait out any load still running
  task automatic set_radius(logic [CFG_W-1:0] v);
    drain();
    while (in_stall_o) @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_data_i <= v;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    cfg_valid_i <= 1'b0;
    link_radius = v;
  endtask

  function automatic in_t noise_beat();
    in_t b;
    logic [127:0] raw;
    raw = {$urandom, $urandom, $urandom, $urandom};
    b = raw[$bits(in_t)-1:0];
    if (b.req_type == REQ_LOAD && stored_nodes >= 14) b.first_node = 1'b1;
    return b;
  endfunction

  function automatic in_t load_beat(bit first, int x, int y, int z);
    in_t b;
    b = noise_beat();
    b.req_type = REQ_LOAD;
    b.first_node = first;
    b.pos_x = x[FIELD_W-1:0];
    b.pos_y = y[FIELD_W-1:0];
    b.pos_z = z[FIELD_W-1:0];
    return b;
  endfunction

  function automatic in_t query_beat(int sx, int sy, int sz, int gx, int gy, int gz);
    in_t b;
    b = load_beat($urandom_range(0, 1), sx, sy, sz);
    b.req_type = REQ_QUERY;
    b.goal_x = gx[FIELD_W-1:0];
    b.goal_y = gy[FIELD_W-1:0];
    b.goal_z = gz[FIELD_W-1:0];
    return b;
  endfunction

  function automatic int jitter(int c, int spread);
    return c + int'($urandom_range(0, 2 * spread)) - spread;
  endfunction

  function automatic void add_row(in_t b, bit typed = 0, out_t want = '0);
    row_t r;
    r.kind = ROW_BEAT;
    r.beat = b;
    r.radius = '0;
    r.typed = typed;
    r.want = want;
    rows.insert(rows.size(), r);
  endfunction

  function automatic void add_radius_row(logic [CFG_W-1:0] v);
    row_t r;
    r = '{ROW_RADIUS, '0, v, 0, '0};
    rows.insert(rows.size(), r);
  endfunction

  // One random phase: clusters of loads followed by queries, with some noise
  task automatic random_phase(int tx, int rx, int beats);
    int sent, spread, nl, nq, a, c;
    int cx, cy, cz;
    tx_idle_pct = tx;
    rx_idle_pct = rx;
    sent = 0;
    while (sent < beats) begin
      spread = $urandom_range(1, 3000);
      case ($urandom_range(0, 9))
        0:       set_radius('0);
        1:       set_radius(RADIUS_MAX);
        default: set_radius(CFG_W'(spread * spread * $urandom_range(1, 4)));
      endcase
      cx = $signed($urandom_range(0, 65535) - 32768);
      cy = $signed($urandom_range(0, 65535) - 32768);
      cz = $signed($urandom_range(0, 65535) - 32768);
      nl = $urandom_range(2, 12);
      for (int i = 0; i < nl; i++) begin
        send_beat(load_beat(i == 0, jitter(cx, 2 * spread), jitter(cy, 2 * spread),
                            jitter(cz, 2 * spread)));
        sent++;
      end
      nq = $urandom_range(1, 4);
      for (int i = 0; i < nq; i++) begin
        a = $urandom_range(0, stored_nodes - 1);
        c = $urandom_range(0, stored_nodes - 1);
        if ($urandom_range(0, 9) == 0) begin
          send_beat(noise_beat());
        end else begin
          send_beat(query_beat(jitter(node_px[a], 50), jitter(node_py[a], 50),
                               jitter(node_pz[a], 50), jitter(node_px[c], 50),
                               jitter(node_py[c], 50), jitter(node_pz[c], 50)));
        end
        sent++;
      end
    end
  endtask

  // -------------------------------------------------------------------- main
  initial begin
    out_t none, corner;
    none = '0;
    none.last = 1'b1;
    corner = '{1'b1, '0, -16'sd32768, -16'sd32768, -16'sd32768, 1'b1};

    // Empty table, extremes, radius edges, ties and a lone node path
    add_row(query_beat(0, 0, 0, 100, 100, 100), 1, none);
    add_row(load_beat(1, -32768, -32768, -32768));
    add_row(load_beat(0, 32767, 32767, 32767));
    add_row(load_beat(0, 0, 0, 0));
    add_row(query_beat(-32768, -32768, -32768, -32000, -32000, -32000), 1, corner);
    add_row(query_beat(-32768, -32768, -32768, 32767, 32767, 32767), 1, none);
    add_radius_row(RADIUS_MAX);
    add_row(load_beat(1, -32768, -32768, -32768));
    add_row(load_beat(0, 32767, 32767, 32767));
    add_row(load_beat(0, 0, 0, 0));
    add_row(query_beat(-32768, -32768, -32768, 32767, 32767, 32767));
    add_row(query_beat(32767, 32767, 32767, -32768, -32768, -32768));
    add_radius_row(38'd10000);
    add_row(load_beat(1, 100, 0, 0));
    add_row(load_beat(0, 200, 0, 0));
    add_row(load_beat(0, 300, 0, 0));
    add_row(load_beat(0, 200, 0, 0));
    add_row(load_beat(0, 400, 10, -5));
    add_row(query_beat(150, 0, 0, 400, 10, -5));
    add_row(query_beat(400, 0, 0, 100, 0, 0));
    add_row(query_beat(-5000, 0, 0, 250, 0, 0));
    add_row(query_beat(200, 0, 0, 200, 0, 0));

    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (rows[i]) begin
      if (rows[i].kind == ROW_RADIUS) begin
        set_radius(rows[i].radius);
      end else begin
        send_beat(rows[i].beat, !rows[i].typed);
        if (rows[i].typed && rows[i].beat.req_type == REQ_QUERY)
          want_beat(rows[i].want);
      end
    end

    // Fill the table, try one more load, then query across it
    set_radius(38'd4096);
    for (int i = 0; i < NODES; i++)
      send_beat(load_beat(i == 0, (i % 8) * 64, (i / 8) * 64, 0));
    send_beat(load_beat(0, 20000, 20000, 20000));
    send_beat(query_beat(0, 0, 0, 7 * 64, 7 * 64, 0));
    send_beat(query_beat(20000, 20000, 20000, 0, 0, 0));

    random_phase(22, 84, 35);
    random_phase(84, 22, 35);

    // Hold the receiver off while queries keep coming, then pause for the drain
    set_radius(38'd1000000);
    tx_idle_pct = 0;
    rx_idle_pct = 0;
    for (int i = 0; i < 6; i++) send_beat(load_beat(i == 0, i * 900, 0, 0));
    hold_req = hold_req + 1;
    for (int i = 0; i < 6; i++) send_beat(query_beat(0, 0, 0, 5 * 900, 0, i));
    drain();
    random_phase(0, 0, 35);

    drain();
    repeat (LOAD_WAIT) @(posedge clk_i);
    if (mismatches == 0 && path_q.size() == 0) begin
      $display("radius_graph_a_star_path_unit: match");
    end else begin
      $display("radius_graph_a_star_path_unit: mismatch");
    end
    $finish;
  end

endmodule
